/* hdl/dq_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded double-ended queue.
// -----------------------------------------------------------------------------
package dq_pkg;

	// Ring size and the widths that follow from it
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	// Payload widths
	localparam int WORD_W  = 32;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic take;      // register the request and update the ring
		logic load_pop;  // capture the word read from the store
	} dq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_read; // the offered request is a pop on a non-empty queue
	} dq_sts_t;

endpackage
`default_nettype wire

/* hdl/dq_ram.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* hdl/dq_ctrl.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// dq_ctrl
// Request sequencer: takes one request, waits for the store read on a pop
// from a non-empty queue, then holds the result until it is transferred.
// -----------------------------------------------------------------------------
module dq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire dq_pkg::dq_sts_t sts,
	output dq_pkg::dq_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign take      = in_valid && in_ready;

	assign cmd.take     = take;
	assign cmd.load_pop = (state_q == S_READ);

	// Advance through take, read and response
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					state_d = sts.need_read ? S_READ : S_RESP;
				end
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hdl/dq_dp.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// dq_dp
// Ring datapath: head and count registers, slot arithmetic, word store and
// result registers.
// -----------------------------------------------------------------------------
module dq_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dq_pkg::dq_cmd_t                    cmd,
	output dq_pkg::dq_sts_t                         sts,
	input  wire logic        [dq_pkg::REQ_W-1:0]    req_type,
	input  wire logic signed [dq_pkg::WORD_W-1:0]   push_value,
	output logic signed      [dq_pkg::WORD_W-1:0]   popped_value,
	output logic             [dq_pkg::STAT_W-1:0]   status,
	output logic             [dq_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IDX_W = dq_pkg::IDX_W;
	localparam int CNT_W = dq_pkg::CNT_W;
	localparam int SUM_W = dq_pkg::SUM_W;

	logic [IDX_W-1:0]          head_q;
	logic [CNT_W-1:0]          count_q;
	logic [dq_pkg::WORD_W-1:0] popped_q;
	logic [dq_pkg::STAT_W-1:0] status_q;

	logic                      is_push;
	logic                      is_front;
	logic                      full;
	logic                      empty;
	logic [IDX_W-1:0]          head_dec;
	logic [IDX_W-1:0]          head_inc;
	logic [SUM_W-1:0]          sum_push;
	logic [SUM_W-1:0]          sum_pop;
	logic [SUM_W-1:0]          wrap_push;
	logic [SUM_W-1:0]          wrap_pop;
	logic [IDX_W-1:0]          waddr;
	logic [IDX_W-1:0]          raddr;
	logic                      we;
	logic [dq_pkg::WORD_W-1:0] rdata;
	logic [31:0]               count_ext;

	// Decode the request and the ring state
	assign is_push  = (req_type == dq_pkg::REQ_PUSH_HEAD)
		|| (req_type == dq_pkg::REQ_PUSH_TAIL);
	assign is_front = (req_type == dq_pkg::REQ_PUSH_HEAD)
		|| (req_type == dq_pkg::REQ_POP_HEAD);
	assign full     = (count_q == CNT_W'(dq_pkg::DEPTH));
	assign empty    = (count_q == '0);

	assign sts.need_read = !is_push && !empty;

	// Step the head around the ring
	assign head_dec = (head_q == '0) ? IDX_W'(dq_pkg::DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;

	// Back slots: one past the back for a push, the back itself for a pop
	assign sum_push  = SUM_W'(head_q) + SUM_W'(count_q);
	assign sum_pop   = sum_push - 1'b1;
	assign wrap_push = (sum_push >= SUM_W'(dq_pkg::DEPTH))
		? sum_push - SUM_W'(dq_pkg::DEPTH) : sum_push;
	assign wrap_pop  = (sum_pop >= SUM_W'(dq_pkg::DEPTH))
		? sum_pop - SUM_W'(dq_pkg::DEPTH) : sum_pop;

	assign waddr = is_front ? head_dec : wrap_push[IDX_W-1:0];
	assign raddr = is_front ? head_q : wrap_pop[IDX_W-1:0];
	assign we    = cmd.take && is_push && !full;

	dq_ram #(
		.WIDTH(dq_pkg::WORD_W),
		.DEPTH(dq_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(push_value),
		.re   (cmd.take && sts.need_read),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Update head and count on a taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.take) begin
			if (is_push) begin
				if (!full) begin
					count_q <= count_q + 1'b1;
					if (is_front) begin
						head_q <= head_dec;
					end
				end
			end else if (!empty) begin
				count_q <= count_q - 1'b1;
				if (is_front) begin
					head_q <= head_inc;
				end
			end
		end
	end

	// Hold the result fields; a pop word is loaded from the store's registered read in the read state
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			popped_q <= '1;
			if (is_push) begin
				status_q <= full ? dq_pkg::ST_FULL : dq_pkg::ST_OK;
			end else begin
				status_q <= empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
			end
		end else if (cmd.load_pop) begin
			popped_q <= rdata;
		end
	end

	assign count_ext    = 32'(count_q);
	assign popped_value = popped_q;
	assign status       = status_q;
	assign entry_count  = count_ext[dq_pkg::COUNT_W-1:0];

endmodule
`default_nettype wire

/* hdl/double_ended_queue.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words held in a ring buffer.
// A push result goes from the idle state straight to the response state;
// a pop on a non-empty queue first passes the read state for the store's
// registered read. Flow: one request at a time; the sequencer holds each
// result until it is transferred before it takes the next request.
// Reset: arst_n clears the head, the count and the sequencer; the word
// store is not cleared, since only words written by a push are ever read.
// -----------------------------------------------------------------------------
module double_ended_queue (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic        [dq_pkg::REQ_W-1:0]   req_type,
	input  wire logic signed [dq_pkg::WORD_W-1:0]  push_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed      [dq_pkg::WORD_W-1:0]  popped_value,
	output logic             [dq_pkg::STAT_W-1:0]  status,
	output logic             [dq_pkg::COUNT_W-1:0] entry_count
);

	dq_pkg::dq_cmd_t cmd;
	dq_pkg::dq_sts_t sts;

	dq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.push_value  (push_value),
		.popped_value(popped_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire
